// ===== rtl/core/c2s_pkg.sv =====
// Shared widths, constants and types for the cartesian to spherical core.
// Used by the rotation pass, the gain compensation unit and the top level.
// Depends on nothing.
package c2s_pkg;

  // Field widths of the stream items.
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;

  // Rotation steps per vectoring pass and fraction bits inside the rotators.
  localparam int STEPS = 16;
  localparam int GUARD = 8;

  // Internal datapath widths: rotator coordinates and angle accumulators.
  localparam int WORK_W = COORD_W + GUARD + 4;
  localparam int TURN_W = 32;
  localparam int ACC_W  = TURN_W + 2;
  localparam int GAIN_W = 32;

  // Rounding shift from turn units to output angle units.
  localparam int ASH = TURN_W - ANGLE_W;

  // Reciprocal of the rotation gain for sixteen steps, unsigned Q0.32.
  localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131497;

  // Arctangent of 2^-i as a fraction of a full turn, 2^32 units per turn.
  localparam logic [TURN_W-1:0] ATAN_TURN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Sideband that travels with an item: one carried word and zero flags.
  typedef struct packed {
    logic [COORD_W-1:0] word;
    logic               xy_zero;
    logic               xyz_zero;
  } side_t;

endpackage

// ===== rtl/core/c2s_cordic_pass.sv =====
// One vectoring pass: STEPS registered rotation stages that drive y to zero.
// Each stage adds or subtracts one arctangent step to the angle accumulator.
// Depends on c2s_pkg.
module c2s_cordic_pass import c2s_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [WORK_W-1:0] x_in,
  input  logic signed [WORK_W-1:0] y_in,
  input  logic signed [ACC_W-1:0]  acc_in,
  input  side_t                    side_in,
  output logic                     out_valid,
  output logic signed [WORK_W-1:0] x_out,
  output logic signed [ACC_W-1:0]  acc_out,
  output side_t                    side_out
);

  logic                     v_r   [0:STEPS-1];
  logic signed [WORK_W-1:0] x_r   [0:STEPS-1];
  logic signed [WORK_W-1:0] y_r   [0:STEPS-1];
  logic signed [ACC_W-1:0]  acc_r [0:STEPS-1];
  side_t                    side_r [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                     va;
    logic signed [WORK_W-1:0] xa;
    logic signed [WORK_W-1:0] ya;
    logic signed [ACC_W-1:0]  acca;
    side_t                    sa;
    logic signed [WORK_W-1:0] dx;
    logic signed [WORK_W-1:0] dy;
    logic signed [ACC_W-1:0]  ang;
    logic signed [WORK_W-1:0] x_nxt;
    logic signed [WORK_W-1:0] y_nxt;
    logic signed [ACC_W-1:0]  acc_nxt;

    // The first stage takes the pass input, later ones the previous stage.
    if (i == 0) begin : g_first
      assign va   = in_valid;
      assign xa   = x_in;
      assign ya   = y_in;
      assign acca = acc_in;
      assign sa   = side_in;
    end else begin : g_next
      assign va   = v_r[i-1];
      assign xa   = x_r[i-1];
      assign ya   = y_r[i-1];
      assign acca = acc_r[i-1];
      assign sa   = side_r[i-1];
    end

    assign dx  = ya >>> i;
    assign dy  = xa >>> i;
    assign ang = signed'({{(ACC_W-TURN_W){1'b0}}, ATAN_TURN[i]});

    // Rotate toward the x axis; a zero y counts as non-negative.
    always_comb begin
      if (!ya[WORK_W-1]) begin
        x_nxt   = xa + dx;
        y_nxt   = ya - dy;
        acc_nxt = acca + ang;
      end else begin
        x_nxt   = xa - dx;
        y_nxt   = ya + dy;
        acc_nxt = acca - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= va;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        acc_r[i]  <= acc_nxt;
        side_r[i] <= sa;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign x_out     = x_r[STEPS-1];
  assign acc_out   = acc_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

// ===== rtl/core/c2s_gain_comp.sv =====
// Gain compensation: multiplies a length by 1/K in Q0.32, rounded half up.
// Two stages: the product register, then the rounding register.
// Depends on c2s_pkg.
module c2s_gain_comp import c2s_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [WORK_W-1:0] value_in,
  input  logic [ANGLE_W-1:0]       angle_in,
  input  side_t                    side_in,
  output logic                     out_valid,
  output logic signed [WORK_W-1:0] value_out,
  output logic [ANGLE_W-1:0]       angle_out,
  output side_t                    side_out
);

  localparam int MAG_W  = WORK_W - 1;
  localparam int PROD_W = MAG_W + GAIN_W;

  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W:0]     prod_rnd;
  logic                v1_r;
  logic [ANGLE_W-1:0]  angle1_r;
  side_t               side1_r;
  logic                v2_r;
  logic [MAG_W-1:0]    res_r;
  logic [ANGLE_W-1:0]  angle2_r;
  side_t               side2_r;

  // Negative lengths do not occur in range but clamp to zero all the same.
  assign mag = (value_in > 0) ? value_in[MAG_W-1:0] : '0;

  // Round half up at bit 31 and keep the integer part.
  assign prod_rnd = {1'b0, prod_r} + {{(PROD_W+1-GAIN_W){1'b0}}, 1'b1, {(GAIN_W-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= PROD_W'(mag) * PROD_W'(INV_GAIN);
      angle1_r <= angle_in;
      side1_r  <= side_in;
      res_r    <= prod_rnd[PROD_W-1:GAIN_W];
      angle2_r <= angle1_r;
      side2_r  <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign value_out = signed'({1'b0, res_r});
  assign angle_out = angle2_r;
  assign side_out  = side2_r;

endmodule

// ===== rtl/core/cartesian_to_spherical_core.sv =====
// Top level of the cartesian to spherical core: front stage, two vectoring
// passes with gain compensation, output register and skid stage.
// Depends on c2s_pkg, c2s_cordic_pass and c2s_gain_comp.
//
//   Channel   Direction  Item contents (tdata, lowest bits first)
//   in_*      slave      x_coord[15:0], y_coord[31:16], z_coord[47:32]
//   out_*     master     azimuth_angle[15:0], polar_angle[31:16], radius[47:32]
//
// One item enters per clock cycle while the skid register is free. There is
// one front stage, sixteen rotation stages per pass, two gain stages per pass
// and the output register. Reset clears all valid bits at once. When the output
// stalls, one more item parks in the skid register and the whole pipeline then holds.
module cartesian_to_spherical_core import c2s_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_coord, y_coord, z_coord
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // azimuth_angle, polar_angle, radius
);

  localparam int POL_W = ACC_W - ASH;
  localparam int RAD_W = WORK_W - GUARD;
  localparam logic signed [POL_W-1:0] POL_LIM = POL_W'(1) <<< (ANGLE_W - 2);

  logic                     en;
  logic [COORD_W-1:0]       x_in;
  logic [COORD_W-1:0]       y_in;
  logic [COORD_W-1:0]       z_in;
  logic signed [WORK_W-1:0] x_sc;
  logic signed [WORK_W-1:0] y_sc;
  logic                     fv_r;
  logic signed [WORK_W-1:0] fx_r;
  logic signed [WORK_W-1:0] fy_r;
  logic signed [ACC_W-1:0]  facc_r;
  side_t                    fside_r;

  logic                     p1_v;
  logic signed [WORK_W-1:0] p1_x;
  logic signed [ACC_W-1:0]  p1_acc;
  side_t                    p1_side;
  logic [TURN_W:0]          az_sum;
  logic [ANGLE_W-1:0]       az;
  logic signed [WORK_W-1:0] rxy_in;

  logic                     g1_v;
  logic signed [WORK_W-1:0] g1_val;
  logic [ANGLE_W-1:0]       g1_ang;
  side_t                    g1_side;
  logic signed [WORK_W-1:0] q_in;
  side_t                    p2_side_in;

  logic                     p2_v;
  logic signed [WORK_W-1:0] p2_x;
  logic signed [ACC_W-1:0]  p2_acc;
  side_t                    p2_side;
  logic signed [ACC_W-1:0]  pol_sum;
  logic signed [POL_W-1:0]  pol_full;
  logic [ANGLE_W-1:0]       pol;

  logic                     g2_v;
  logic signed [WORK_W-1:0] g2_val;
  logic [ANGLE_W-1:0]       g2_ang;
  side_t                    g2_side;
  logic [WORK_W:0]          rad_sum;
  logic [RAD_W:0]           rad_full;
  logic [COORD_W-1:0]       rad;
  logic [47:0]              res;

  logic                     out_v_r;
  logic [47:0]              out_r;
  logic                     skid_v_r;
  logic [47:0]              skid_r;

  // The pipeline moves whenever the skid register is free.
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Front stage: scale to guard bits and fold the left half plane over.
  assign x_in = in_tdata[15:0];
  assign y_in = in_tdata[31:16];
  assign z_in = in_tdata[47:32];
  assign x_sc = signed'({{(WORK_W-COORD_W-GUARD){x_in[COORD_W-1]}}, x_in, {GUARD{1'b0}}});
  assign y_sc = signed'({{(WORK_W-COORD_W-GUARD){y_in[COORD_W-1]}}, y_in, {GUARD{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[COORD_W-1]) begin
        fx_r   <= -x_sc;
        fy_r   <= -y_sc;
        facc_r <= ACC_W'(1) <<< (TURN_W - 1);
      end else begin
        fx_r   <= x_sc;
        fy_r   <= y_sc;
        facc_r <= '0;
      end
      fside_r.word     <= z_in;
      fside_r.xy_zero  <= (x_in == '0) && (y_in == '0);
      fside_r.xyz_zero <= (x_in == '0) && (y_in == '0) && (z_in == '0);
    end
  end

  // First pass: azimuth and planar length.
  c2s_cordic_pass u_pass_xy (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fv_r),
    .x_in     (fx_r),
    .y_in     (fy_r),
    .acc_in   (facc_r),
    .side_in  (fside_r),
    .out_valid(p1_v),
    .x_out    (p1_x),
    .acc_out  (p1_acc),
    .side_out (p1_side)
  );

  // Azimuth rounded half up; a full turn wraps to zero.
  assign az_sum = {1'b0, p1_acc[TURN_W-1:0]} + (TURN_W+1)'(1 << (ASH - 1));
  assign az     = p1_side.xy_zero ? '0 : az_sum[TURN_W-1:ASH];
  assign rxy_in = p1_side.xy_zero ? '0 : p1_x;

  c2s_gain_comp u_gain_xy (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p1_v),
    .value_in (rxy_in),
    .angle_in (az),
    .side_in  (p1_side),
    .out_valid(g1_v),
    .value_out(g1_val),
    .angle_out(g1_ang),
    .side_out (g1_side)
  );

  // Second pass: planar length against z; the azimuth rides in the sideband.
  assign q_in = signed'({{(WORK_W-COORD_W-GUARD){g1_side.word[COORD_W-1]}},
                         g1_side.word, {GUARD{1'b0}}});

  always_comb begin
    p2_side_in      = g1_side;
    p2_side_in.word = g1_ang;
  end

  c2s_cordic_pass u_pass_rz (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (g1_v),
    .x_in     (g1_val),
    .y_in     (q_in),
    .acc_in   ('0),
    .side_in  (p2_side_in),
    .out_valid(p2_v),
    .x_out    (p2_x),
    .acc_out  (p2_acc),
    .side_out (p2_side)
  );

  // Polar angle rounded half up, held to a quarter turn, zero for a zero vector.
  assign pol_sum  = p2_acc + (ACC_W'(1) <<< (ASH - 1));
  assign pol_full = POL_W'(pol_sum >>> ASH);

  always_comb begin
    if (p2_side.xyz_zero) begin
      pol = '0;
    end else if (pol_full > POL_LIM) begin
      pol = ANGLE_W'(POL_LIM);
    end else if (pol_full < -POL_LIM) begin
      pol = ANGLE_W'(-POL_LIM);
    end else begin
      pol = pol_full[ANGLE_W-1:0];
    end
  end

  c2s_gain_comp u_gain_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p2_v),
    .value_in (p2_x),
    .angle_in (pol),
    .side_in  (p2_side),
    .out_valid(g2_v),
    .value_out(g2_val),
    .angle_out(g2_ang),
    .side_out (g2_side)
  );

  // Radius: drop the guard bits with rounding and saturate to the field.
  assign rad_sum  = {1'b0, g2_val} + (WORK_W+1)'(1 << (GUARD - 1));
  assign rad_full = rad_sum[WORK_W:GUARD];

  always_comb begin
    if (g2_side.xyz_zero) begin
      rad = '0;
    end else if (rad_full > (RAD_W+1)'({COORD_W{1'b1}})) begin
      rad = '1;
    end else begin
      rad = rad_full[COORD_W-1:0];
    end
  end

  assign res = {rad, g2_ang, g2_side.word};

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || g2_v;
      skid_v_r <= 1'b0;
    end else if (g2_v && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

// ===== verif/c2s_result_check.sv =====
`timescale 1ns / 100ps
// Result checker for the cartesian to spherical core: computes the expected
// azimuth, polar angle and radius for every accepted item and compares them.
// Depends on c2s_pkg for the field widths.
module c2s_result_check import c2s_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // x_coord, y_coord, z_coord
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // azimuth_angle, polar_angle, radius
  output int          mismatch_count,
  output int          results_pending
);

  // Fraction bits carried through the rotations and the reciprocal gain.
  localparam int FRAC_BITS = 8;
  localparam int ROT_STEPS = 16;
  localparam longint unsigned RECIP_GAIN = 64'd2608131497;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_STEP [0:ROT_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Packed like out_tdata, so a result word unpacks straight into it.
  typedef struct packed {
    logic        [COORD_W-1:0] radius;
    logic signed [ANGLE_W-1:0] polar;
    logic        [ANGLE_W-1:0] azimuth;
  } sph_t;

  typedef struct {
    int          seq;
    sph_t        sph;
  } pending_t;

  pending_t expected_q[$];
  int       items_seen = 0;
  int       error_tally = 0;

  assign mismatch_count = error_tally;

  // Turns (u, v) until v is near zero; returns the angle turned through.
  function automatic longint rotate_to_axis(inout longint u, inout longint v);
    longint acc;
    longint du;
    longint dv;
    acc = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u += du;
        v -= dv;
        acc += longint'(ATAN_STEP[i]);
      end else begin
        u -= du;
        v += dv;
        acc -= longint'(ATAN_STEP[i]);
      end
    end
    return acc;
  endfunction

  // Multiply by the reciprocal gain in Q0.32, rounding half up.
  function automatic longint unsigned scale_by_gain(longint unsigned a);
    return (a >> 32) * RECIP_GAIN +
           (((a & 64'hFFFF_FFFF) * RECIP_GAIN + 64'h8000_0000) >> 32);
  endfunction

  function automatic sph_t spherical_of(logic signed [COORD_W-1:0] xc,
                                        logic signed [COORD_W-1:0] yc,
                                        logic signed [COORD_W-1:0] zc);
    longint          u;
    longint          v;
    longint          turn_xy;
    longint          turn_z;
    longint          pol;
    longint unsigned az32;
    longint unsigned planar;
    longint unsigned rad;
    sph_t            r;
    // First pass: azimuth and planar length, folded into the right half.
    u = longint'(xc) * 256;
    v = longint'(yc) * 256;
    turn_xy = 0;
    if (u < 0) begin
      u = -u;
      v = -v;
      turn_xy = 64'sh8000_0000;
    end
    turn_xy += rotate_to_axis(u, v);
    az32 = $unsigned(turn_xy) & 64'hFFFF_FFFF;
    r.azimuth = ANGLE_W'((az32 + 64'd32768) >> 16);
    if (xc == 0 && yc == 0) begin
      r.azimuth = '0;
      u = 0;
    end
    planar = scale_by_gain(u > 0 ? $unsigned(u) : 64'd0);

    // Second pass: elevation from the planar length and z.
    u = $signed(planar);
    v = longint'(zc) * 256;
    turn_z = rotate_to_axis(u, v);
    pol = (turn_z + 64'sd32768) >>> 16;
    if (pol > 16384) pol = 16384;
    if (pol < -16384) pol = -16384;

    // Radius: gain compensated again, guard bits rounded off, saturated.
    rad = scale_by_gain(u > 0 ? $unsigned(u) : 64'd0);
    rad = (rad + 64'd128) >> FRAC_BITS;
    if (rad > 64'd65535) rad = 64'd65535;

    if (xc == 0 && yc == 0 && zc == 0) begin
      pol = 0;
      rad = 0;
    end
    r.polar = ANGLE_W'(pol);
    r.radius = COORD_W'(rad);
    return r;
  endfunction

  // Prints one line per problem and counts every one.
  task automatic report_error(string what, int seq, longint want, longint got);
    $display("ERROR %0t: item %0d %s: expected %0d, got %0d",
             $realtime, seq, what, want, got);
    error_tally++;
  endtask

  // Compare each result with the oldest expectation, then record new items.
  always @(posedge clk) begin : watch
    pending_t head;
    sph_t     got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          report_error("result with nothing expected", -1, 0, out_tdata);
        end else begin
          head = expected_q.pop_front();
          if (got.azimuth !== head.sph.azimuth)
            report_error("azimuth_angle", head.seq, head.sph.azimuth, got.azimuth);
          if (got.polar !== head.sph.polar)
            report_error("polar_angle", head.seq, head.sph.polar, got.polar);
          if (got.radius !== head.sph.radius)
            report_error("radius", head.seq, head.sph.radius, got.radius);
        end
      end
      if (in_tvalid && in_tready) begin
        head.seq = items_seen;
        head.sph = spherical_of(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
        expected_q.push_back(head);
        items_seen++;
      end
      results_pending <= expected_q.size();
    end
  end

endmodule

// ===== verif/cartesian_to_spherical_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the cartesian to spherical core: clock, reset, stimulus
// with random idling on both sides, watchdog and verdict.
// Depends on the core and c2s_result_check.
module cartesian_to_spherical_core_tb;

  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_LIMIT    = 3000;
  localparam int FIRST_BURST   = 120;
  localparam int BURST_SPACING = 350;
  localparam int BURST_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [47:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;
  int          mismatch_count;
  int          results_pending;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cartesian_to_spherical_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  c2s_result_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_vector(input logic signed [15:0] xc,
                             input logic signed [15:0] yc,
                             input logic signed [15:0] zc);
    in_tdata <= {zc, yc, xc};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic hold_input(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering items until every expected result has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Mostly full-range values, with small, shifted-down and extreme ones mixed in.
  function automatic logic [15:0] rand_coord();
    logic signed [15:0] w;
    int                 pick;
    pick = $urandom_range(0, 9);
    w = 16'($urandom);
    if (pick < 5) return w;
    if (pick < 7) return 16'($signed($urandom_range(0, 32)) - 16);
    if (pick < 8) begin
      case ($urandom_range(0, 5))
        0: return 16'h8000;
        1: return 16'h8001;
        2: return 16'h7FFF;
        3: return 16'hFFFF;
        4: return 16'h0001;
        default: return 16'h0000;
      endcase
    end
    return w >>> $urandom_range(1, 14);
  endfunction

  // Gap before the next item: mostly none, some short, a few long.
  function automatic int pick_gap(bit steady);
    int pick;
    pick = $urandom_range(0, 19);
    if (steady || pick < 11) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Result side: ready stretches and stalls, with long hold-offs at set points
  // so that the pipeline fills up and pushes back on the input.
  initial begin : result_sink
    int taken;
    int burst_at;
    int stall;
    int run_len;
    int pick;
    taken = 0;
    burst_at = FIRST_BURST;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 19);
      if (taken >= burst_at) begin
        stall = BURST_CYCLES;
        burst_at += BURST_SPACING;
      end else if (pick < 8) begin
        stall = 0;
      end else if (pick < 18) begin
        stall = $urandom_range(1, 4);
      end else begin
        stall = $urandom_range(20, 80);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      run_len = $urandom_range(1, (pick % 3 == 0) ? 60 : 6);
      repeat (run_len) begin
        @(posedge clk);
        if (out_tvalid) taken++;
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cartesian_to_spherical_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] xc;
    logic [15:0] yc;
    logic [15:0] zc;
    int          gap;
    int          pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: origin, axes, extremes, azimuth wrap and elevation limits.
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd1, 16'sd0);
    send_vector(16'sd0, -16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd1);
    send_vector(16'sd0, 16'sd0, -16'sd1);
    send_vector(16'sd0, 16'sd0, 16'sd32767);
    send_vector(16'sd0, 16'sd0, -16'sd32768);
    send_vector(16'sd32767, 16'sd0, 16'sd0);
    send_vector(-16'sd32768, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd32767, 16'sd0);
    send_vector(16'sd0, -16'sd32768, 16'sd0);
    send_vector(16'sd32767, -16'sd1, 16'sd0);
    send_vector(-16'sd32768, -16'sd1, 16'sd5);
    send_vector(-16'sd32768, 16'sd1, -16'sd5);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768, -16'sd32768);
    send_vector(16'sd1, 16'sd1, 16'sd32767);
    send_vector(-16'sd1, -16'sd1, -16'sd32768);
    send_vector(16'sd3, -16'sd4, 16'sd12);
    wait_drained();

    // Random items; every third block of forty runs without gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 39);
      xc = rand_coord();
      yc = rand_coord();
      zc = rand_coord();
      if (pick < 2) begin
        xc = '0;
        yc = '0;
        zc = '0;
      end else if (pick < 4) begin
        xc = '0;
        yc = '0;
      end
      send_vector(xc, yc, zc);
      gap = pick_gap((n / 40) % 3 == 0);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      else if (gap > 0) hold_input(gap);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cartesian_to_spherical_core: match");
    end else begin
      $display("cartesian_to_spherical_core: mismatch");
    end
    $finish;
  end

endmodule
